>>> design/lcp_pkg.sv
package lcp_pkg;

	localparam int PORTS_DEF = 2;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [1:0] LEN_MAX = 2'd3;
	localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
	localparam logic [31:0] VALUE_BAD = 32'hFFFF_FFFF;

	// per-port line state as held in the state memory
	typedef struct packed {
		logic [1:0] len;
		logic [7:0] cmd;
		logic [30:0] acc;
		logic non_digit;
	} line_state_t;

	localparam int STATE_W = $bits(line_state_t);

endpackage

>>> design/line_command_parser.sv
// channel  dir  signals                       fields (lsb up)
// s_       in   tvalid tready tdata tuser     tdata: data_byte[7:0]; tuser: port
// m_       out  tvalid tready tdata tuser     tdata: command[7:0], value[39:8]; tuser: source
//
// accept loads stage 1, whose result loads the output register; one item per cycle
// unless stage 1 stalls; state memory read-modify-write: read at accept, write as it advances
// a write to the port read in the same cycle is forwarded from the last-write register
// reset clears per-port valid bits, so every port starts with an empty line at once
// a result waiting in the output register stalls only items that would also make a result
module line_command_parser #(
	parameter int PORTS = lcp_pkg::PORTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,   // data_byte[7:0]
	input logic s_tuser,         // port
	output logic m_tvalid,
	input logic m_tready,
	output logic [39:0] m_tdata, // command[7:0], value[39:8]
	output logic m_tuser         // source
);

	import lcp_pkg::*;

	localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

	// stage 1: item whose state is being read back
	logic s1_valid_q;
	logic [IDX_W-1:0] idx_s1;
	logic [7:0] byte_s1;
	logic in_range_s1;

	// last write, for forwarding into a read issued in the same cycle
	logic fwd_valid_q;
	logic [IDX_W-1:0] fwd_addr_q;
	line_state_t fwd_data_q;

	logic [PORTS-1:0] valid_q;

	logic out_valid_q;
	logic [7:0] out_cmd_q;
	logic [31:0] out_value_q;
	logic out_src_q;

	logic s_accept;
	logic [IDX_W-1:0] s_idx;
	logic [STATE_W-1:0] ram_rdata;
	line_state_t cur;
	line_state_t nxt;
	logic is_cr;
	logic is_lf;
	logic is_digit;
	logic [34:0] acc_wide;
	logic [7:0] digit;
	logic gen_result;
	logic s1_adv;
	logic wr_en;
	logic out_load;

	assign s_idx = IDX_W'(s_tuser);
	assign s_accept = s_tvalid && s_tready;

	lcp_ram #(
		.WIDTH(STATE_W),
		.DEPTH(PORTS),
		.ADDR_W(IDX_W)
	) u_state_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(idx_s1),
		.wr_data(nxt),
		.rd_en(s_accept),
		.rd_addr(s_idx),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			idx_s1 <= s_idx;
			byte_s1 <= s_tdata;
			in_range_s1 <= (32'(s_tuser) < PORTS);
		end
	end

	// current state: forwarded write, stored entry, or empty line
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == idx_s1) begin
			cur = fwd_data_q;
		end else if (valid_q[idx_s1]) begin
			cur = line_state_t'(ram_rdata);
		end else begin
			cur = '0;
		end
	end

	assign is_cr = (byte_s1 == CH_CR);
	assign is_lf = (byte_s1 == CH_LF);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit = byte_s1 - CH_ZERO;
	// acc * 10 + digit, checked against the saturation limit
	assign acc_wide = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {27'd0, digit};

	always_comb begin
		nxt = cur;
		if (is_cr) begin
			nxt = '0;
		end else if (!is_lf) begin
			if (cur.len == 2'd0) begin
				nxt.cmd = byte_s1;
			end else if (is_digit) begin
				if (acc_wide > 35'(VALUE_MAX)) begin
					nxt.acc = VALUE_MAX;
				end else begin
					nxt.acc = acc_wide[30:0];
				end
			end else begin
				nxt.non_digit = 1'b1;
			end
			if (cur.len != LEN_MAX) begin
				nxt.len = cur.len + 2'd1;
			end
		end
	end

	assign gen_result = s1_valid_q && in_range_s1 && is_cr && (cur.len >= 2'd2);
	assign s1_adv = s1_valid_q && (!gen_result || !out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign wr_en = s1_adv && in_range_s1;
	assign out_load = s1_adv && gen_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			valid_q <= '0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
			valid_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= idx_s1;
			fwd_data_q <= nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_src_q <= idx_s1[0];
			if (cur.non_digit) begin
				out_cmd_q <= 8'd0;
				out_value_q <= VALUE_BAD;
			end else begin
				out_cmd_q <= cur.cmd;
				out_value_q <= {1'b0, cur.acc};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_value_q, out_cmd_q};
	assign m_tuser = out_src_q;

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |-> !s_tready)
		else $error("input taken while stage 1 is stalled");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_tready))
		else $error("result overwrote a pending result");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[fwd_addr_q])
		else $error("written port not marked valid");

	a_bad_value_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[39]) |-> (m_tdata[7:0] == 8'd0 && m_tdata[39:8] == VALUE_BAD))
		else $error("negative value without the non-numeric form");
`endif

endmodule

>>> design/lcp_ram.sv
module lcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [ADDR_W-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
